// ===== hw/rtl/fire_effect_grid_engine_top_assert.svh =====
// Assertion macros shared by the checker of the fire grid engine.
// Depends on nothing; included by the checker file.
`ifndef FIRE_EFFECT_GRID_ENGINE_TOP_ASSERT_SVH
`define FIRE_EFFECT_GRID_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define FEGE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define FEGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/fege_pkg.sv =====
// Package of the fire grid engine: grid geometry, request codes, palette.
// Depends on nothing; used by every other file of the block but the assertion header.
`timescale 1ns / 1ps

package fege_pkg;

	localparam int GRID_WIDTH   = 32;
	localparam int GRID_HEIGHT  = 24;
	localparam int CELL_COUNT   = GRID_WIDTH * GRID_HEIGHT;
	localparam int BOTTOM_BASE  = (GRID_HEIGHT - 1) * GRID_WIDTH;
	localparam int ADDR_W       = $clog2(CELL_COUNT);
	localparam int COL_W        = $clog2(GRID_WIDTH);
	localparam int ROW_W        = $clog2(GRID_HEIGHT);
	localparam int LEVEL_COUNT  = 37;
	localparam int LEVEL_W      = 6;
	localparam int REQ_TYPE_W   = 2;
	localparam int DECAY_W      = 2;
	localparam int INDEX_W      = 10;
	localparam int COLOR_W      = 24;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(LEVEL_COUNT - 1);

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_PROPAGATE = 2'd0,
		REQ_RESET     = 2'd1,
		REQ_READ      = 2'd2,
		REQ_NONE      = 2'd3
	} req_code_t;

	typedef struct packed {
		logic accept;
		logic sweep;
		logic finish;
	} fege_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic out_free;
	} fege_stat_t;

	localparam logic [COLOR_W-1:0] FLAME_RGB [LEVEL_COUNT] = '{
		24'h070707, 24'h1F0707, 24'h2F0F07, 24'h470F07,
		24'h571707, 24'h671F07, 24'h771F07, 24'h8F2707,
		24'h9F2F07, 24'hAF3F07, 24'hBF4707, 24'hC74707,
		24'hDF4F07, 24'hDF5707, 24'hDF5707, 24'hD75F07,
		24'hD75F07, 24'hD7670F, 24'hCF6F0F, 24'hCF770F,
		24'hCF7F0F, 24'hCF8717, 24'hC78717, 24'hC78F17,
		24'hC7971F, 24'hBF9F1F, 24'hBF9F1F, 24'hBFA727,
		24'hBFA727, 24'hBFAF2F, 24'hB7AF2F, 24'hB7B72F,
		24'hB7B737, 24'hCFCF6F, 24'hDFDF9F, 24'hEFEFC7,
		24'hFFFFFF
	};

	function automatic logic [COLOR_W-1:0] flame_color(input logic [LEVEL_W-1:0] level,
		input logic fmt);
		logic [COLOR_W-1:0] rgb;
		begin
			if (level >= LEVEL_W'(LEVEL_COUNT)) begin
				flame_color = '0;
			end else begin
				rgb = FLAME_RGB[level];
				if (fmt) begin
					flame_color = rgb;
				end else begin
					flame_color = {8'h00, rgb[23:19], rgb[15:10], rgb[7:3]};
				end
			end
		end
	endfunction

endpackage

// ===== hw/rtl/fege_req_if.sv =====
// Request channel of the fire grid engine: valid, ready and request fields.
// Depends on fege_pkg.
`timescale 1ns / 1ps

interface fege_req_if import fege_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [DECAY_W-1:0]    decay;
	logic [INDEX_W-1:0]    cell_index;
	logic                  color_format;

	modport source (output valid, req_type, decay, cell_index, color_format, input ready);
	modport sink (input valid, req_type, decay, cell_index, color_format, output ready);
endinterface

// ===== hw/rtl/fege_rsp_if.sv =====
// Result channel of the fire grid engine: valid, ready and result fields.
// Depends on fege_pkg.
`timescale 1ns / 1ps

interface fege_rsp_if import fege_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               wrote;
	logic [INDEX_W-1:0] written_index;
	logic [LEVEL_W-1:0] written_level;
	logic               frame_done;
	logic [COLOR_W-1:0] color;

	modport source (output valid, wrote, written_index, written_level, frame_done, color,
		input ready);
	modport sink (input valid, wrote, written_index, written_level, frame_done, color,
		output ready);
endinterface

// ===== hw/rtl/fege_ctrl.sv =====
// Controller of the fire grid engine: sequences accept, grid sweep and commit.
// Depends on fege_pkg for the command and status structs and the request codes.
`timescale 1ns / 1ps

module fege_ctrl import fege_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic [REQ_TYPE_W-1:0] req_type,
	output logic                  req_ready,
	input  fege_stat_t            stat,
	output fege_cmd_t             cmd
);

	typedef enum logic [3:0] {
		ST_INIT   = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_SWEEP  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		req_ready  = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_next = (req_type == REQ_RESET) ? ST_SWEEP : ST_FINISH;
				end
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_next = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/fege_dp.sv =====
// Datapath of the fire grid engine: grid memory, cursor, sweep counter,
// palette lookup and result register. Depends on fege_pkg.
`timescale 1ns / 1ps

module fege_dp import fege_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fege_cmd_t             cmd,
	output fege_stat_t            stat,
	input  logic [REQ_TYPE_W-1:0] req_type,
	input  logic [DECAY_W-1:0]    decay,
	input  logic [INDEX_W-1:0]    cell_index,
	input  logic                  color_format,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  wrote,
	output logic [INDEX_W-1:0]    written_index,
	output logic [LEVEL_W-1:0]    written_level,
	output logic                  frame_done,
	output logic [COLOR_W-1:0]    color
);

	logic [LEVEL_W-1:0]    fire_store_q [CELL_COUNT];
	logic [LEVEL_W-1:0]    rdata_q;
	logic [REQ_TYPE_W-1:0] req_type_q;
	logic [DECAY_W-1:0]    decay_q;
	logic                  fmt_q;
	logic                  cell_ok_q;
	logic [COL_W-1:0]      cursor_col_q;
	logic [ROW_W-1:0]      cursor_row_q;
	logic [ADDR_W-1:0]     sweep_cnt_q;
	logic                  out_valid_q;
	logic                  wrote_q;
	logic [INDEX_W-1:0]    written_index_q;
	logic [LEVEL_W-1:0]    written_level_q;
	logic                  frame_done_q;
	logic [COLOR_W-1:0]    color_q;

	logic                  bottom_row;
	logic                  last_col;
	logic [ADDR_W-1:0]     cur_idx;
	logic [ADDR_W-1:0]     below_idx;
	logic [ADDR_W-1:0]     dst_idx;
	logic [LEVEL_W-1:0]    new_level;
	logic                  can_write;
	logic                  is_prop;
	logic                  is_read;
	logic                  in_cell_ok;
	logic                  mem_we;
	logic                  mem_re;
	logic [ADDR_W-1:0]     mem_addr;
	logic [LEVEL_W-1:0]    mem_wdata;

	assign bottom_row = (cursor_row_q == ROW_W'(GRID_HEIGHT - 1));
	assign last_col   = (cursor_col_q == COL_W'(GRID_WIDTH - 1));
	assign cur_idx    = ADDR_W'(cursor_row_q) * ADDR_W'(GRID_WIDTH) + ADDR_W'(cursor_col_q);
	assign below_idx  = cur_idx + ADDR_W'(GRID_WIDTH);
	assign dst_idx    = cur_idx - ADDR_W'(decay_q);
	assign new_level  = (rdata_q > LEVEL_W'(decay_q)) ? (rdata_q - LEVEL_W'(decay_q)) : '0;
	assign can_write  = !bottom_row && (cur_idx >= ADDR_W'(decay_q));
	assign is_prop    = (req_type_q == REQ_PROPAGATE);
	assign is_read    = (req_type_q == REQ_READ);
	assign in_cell_ok = (cell_index < INDEX_W'(CELL_COUNT));

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		priority if (cmd.sweep) begin
			mem_we    = 1'b1;
			mem_addr  = sweep_cnt_q;
			mem_wdata = (sweep_cnt_q >= ADDR_W'(BOTTOM_BASE)) ? LEVEL_MAX : '0;
		end else if (cmd.finish && is_prop && can_write) begin
			mem_we    = 1'b1;
			mem_addr  = dst_idx;
			mem_wdata = new_level;
		end else if (cmd.accept) begin
			mem_re = 1'b1;
			if (req_type == REQ_READ) begin
				mem_addr = in_cell_ok ? ADDR_W'(cell_index) : '0;
			end else if (!bottom_row) begin
				mem_addr = below_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			fire_store_q[mem_addr] <= mem_wdata;
		end else if (mem_re) begin
			rdata_q <= fire_store_q[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_type_q <= req_type;
			decay_q    <= decay;
			fmt_q      <= color_format;
			cell_ok_q  <= in_cell_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_cnt_q  <= '0;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.sweep) begin
				sweep_cnt_q <= stat.sweep_last ? '0 : sweep_cnt_q + 1'b1;
			end
			if (cmd.finish && is_prop) begin
				if (bottom_row) begin
					cursor_row_q <= '0;
					cursor_col_q <= last_col ? '0 : cursor_col_q + 1'b1;
				end else begin
					cursor_row_q <= cursor_row_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			wrote_q         <= is_prop && can_write;
			written_index_q <= (is_prop && can_write) ? INDEX_W'(dst_idx) : '0;
			written_level_q <= (is_prop && can_write) ? new_level : '0;
			frame_done_q    <= is_prop && bottom_row && last_col;
			color_q         <= (is_read && cell_ok_q) ? flame_color(rdata_q, fmt_q) : '0;
		end
	end

	assign stat.sweep_last = (sweep_cnt_q == ADDR_W'(CELL_COUNT - 1));
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign wrote         = wrote_q;
	assign written_index = written_index_q;
	assign written_level = written_level_q;
	assign frame_done    = frame_done_q;
	assign color         = color_q;

endmodule

// ===== hw/rtl/fire_effect_grid_engine_top.sv =====
// Top level of the fire grid engine: joins the controller and the datapath.
// Depends on fege_pkg, fege_req_if, fege_rsp_if, fege_ctrl and fege_dp.
//
//   Channel | Direction | Transfer carries
//   req     | in        | req_type, decay, cell_index, color_format
//   rsp     | out       | wrote, written_index, written_level, frame_done, color
//
// Propagate and read requests read the single-port grid memory in the transfer
// cycle and write or look it up in the finish state once the output is free.
// A grid reset request sets all 768 cells: bottom row to LEVEL_MAX, rest 0.
// After arst_n the same sweep runs with req.ready low.
// A finished result waits in the output register while the next request is
// accepted; that request's commit holds until the register is free.
`timescale 1ns / 1ps

module fire_effect_grid_engine_top import fege_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	fege_req_if.sink   req,
	fege_rsp_if.source rsp
);

	fege_cmd_t  cmd;
	fege_stat_t stat;

	fege_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fege_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_type      (req.req_type),
		.decay         (req.decay),
		.cell_index    (req.cell_index),
		.color_format  (req.color_format),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.wrote         (rsp.wrote),
		.written_index (rsp.written_index),
		.written_level (rsp.written_level),
		.frame_done    (rsp.frame_done),
		.color         (rsp.color)
	);

endmodule

// ===== hw/rtl/fege_checker.sv =====
// Port-level checker of the fire grid engine and its bind to the top level.
// Depends on fege_pkg and fire_effect_grid_engine_top_assert.svh.
`timescale 1ns / 1ps
`include "fire_effect_grid_engine_top_assert.svh"

module fege_checker import fege_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic               wrote,
	input logic [INDEX_W-1:0] written_index,
	input logic [LEVEL_W-1:0] written_level,
	input logic               frame_done,
	input logic [COLOR_W-1:0] color
);

	`FEGE_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
	`FEGE_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_valid && req_ready, !req_ready, "ready after transfer")
	`FEGE_ASSERT_NOW(a_no_write_zero, clk, arst_n, rsp_valid && !wrote, written_index == '0 && written_level == '0, "write fields set")
	`FEGE_ASSERT_NOW(a_color_alone, clk, arst_n, rsp_valid && color != '0, !wrote && !frame_done, "color with step")
	`FEGE_ASSERT_NOW(a_level_range, clk, arst_n, rsp_valid && wrote, written_level <= LEVEL_MAX, "level out of range")

endmodule

bind fire_effect_grid_engine_top fege_checker u_fege_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.wrote         (rsp.wrote),
	.written_index (rsp.written_index),
	.written_level (rsp.written_level),
	.frame_done    (rsp.frame_done),
	.color         (rsp.color)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for fire_effect_grid_engine_top: a directed table, then random requests.
// Results are checked against typed table rows or a local model of grid, cursor and palette.
// Depends on fege_pkg, fege_req_if, fege_rsp_if and the engine RTL.

module tb_top;
	import fege_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 1000;
	localparam int PALETTE_SIZE = 37;
	localparam int TOP_LEVEL    = 36;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		req_code_t   kind;
		logic [1:0]  decay;
		logic [9:0]  cell_idx;
		logic        fmt;
	} fire_req_t;

	typedef struct packed {
		logic        wrote;
		logic [9:0]  written_index;
		logic [5:0]  written_level;
		logic        frame_done;
		logic [23:0] color;
	} fire_rsp_t;

	typedef struct packed {
		fire_req_t rq;
		logic      typed;
		fire_rsp_t rs;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n;

	fege_req_if req_ch ();
	fege_rsp_if rsp_ch ();

	fire_effect_grid_engine_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [23:0] ember_rgb [PALETTE_SIZE] = '{
		24'h070707, 24'h1F0707, 24'h2F0F07, 24'h470F07,
		24'h571707, 24'h671F07, 24'h771F07, 24'h8F2707,
		24'h9F2F07, 24'hAF3F07, 24'hBF4707, 24'hC74707,
		24'hDF4F07, 24'hDF5707, 24'hDF5707, 24'hD75F07,
		24'hD75F07, 24'hD7670F, 24'hCF6F0F, 24'hCF770F,
		24'hCF7F0F, 24'hCF8717, 24'hC78717, 24'hC78F17,
		24'hC7971F, 24'hBF9F1F, 24'hBF9F1F, 24'hBFA727,
		24'hBFA727, 24'hBFAF2F, 24'hB7AF2F, 24'hB7B72F,
		24'hB7B737, 24'hCFCF6F, 24'hDFDF9F, 24'hEFEFC7,
		24'hFFFFFF
	};

	step_row_t step_rows [19] = '{
		'{'{REQ_READ,      2'd0, 10'd0,    1'b0}, 1'b1, '{1'b0, 10'd0, 6'd0, 1'b0, 24'h000020}},
		'{'{REQ_READ,      2'd0, 10'd0,    1'b1}, 1'b1, '{1'b0, 10'd0, 6'd0, 1'b0, 24'h070707}},
		'{'{REQ_READ,      2'd3, 10'd767,  1'b1}, 1'b1, '{1'b0, 10'd0, 6'd0, 1'b0, 24'hFFFFFF}},
		'{'{REQ_READ,      2'd1, 10'd767,  1'b0}, 1'b1, '{1'b0, 10'd0, 6'd0, 1'b0, 24'h00FFFF}},
		'{'{REQ_READ,      2'd0, 10'd736,  1'b1}, 1'b1, '{1'b0, 10'd0, 6'd0, 1'b0, 24'hFFFFFF}},
		'{'{REQ_READ,      2'd0, 10'd735,  1'b1}, 1'b1, '{1'b0, 10'd0, 6'd0, 1'b0, 24'h070707}},
		'{'{REQ_READ,      2'd0, 10'd768,  1'b1}, 1'b1, '0},
		'{'{REQ_READ,      2'd3, 10'd1023, 1'b1}, 1'b1, '0},
		'{'{REQ_READ,      2'd2, 10'd1023, 1'b0}, 1'b1, '0},
		'{'{REQ_NONE,      2'd3, 10'd1023, 1'b1}, 1'b1, '0},
		'{'{REQ_PROPAGATE, 2'd3, 10'd1023, 1'b1}, 1'b1, '0},
		'{'{REQ_PROPAGATE, 2'd0, 10'd0,    1'b0}, 1'b0, '0},
		'{'{REQ_PROPAGATE, 2'd1, 10'd512,  1'b1}, 1'b0, '0},
		'{'{REQ_PROPAGATE, 2'd2, 10'd0,    1'b0}, 1'b0, '0},
		'{'{REQ_RESET,     2'd3, 10'd1023, 1'b1}, 1'b1, '0},
		'{'{REQ_READ,      2'd0, 10'd767,  1'b0}, 1'b1, '{1'b0, 10'd0, 6'd0, 1'b0, 24'h00FFFF}},
		'{'{REQ_PROPAGATE, 2'd3, 10'd0,    1'b0}, 1'b0, '0},
		'{'{REQ_NONE,      2'd0, 10'd0,    1'b0}, 1'b1, '0},
		'{'{REQ_READ,      2'd0, 10'd125,  1'b1}, 1'b0, '0}
	};

	logic [5:0]  fire_levels [CELL_COUNT];
	int unsigned cur_col;
	int unsigned cur_row;
	fire_rsp_t   pending_results [$];
	bit          calm = 1'b0;
	int          fail_count = 0;
	int          n_items = 0;
	int          n_writes = 0;
	int          n_frames = 0;
	int          n_reads = 0;
	int          n_resets = 0;

	always #1 clk = ~clk;

	function automatic void reset_grid();
		for (int i = 0; i < CELL_COUNT; i++) begin
			fire_levels[i] = (i >= (GRID_HEIGHT - 1) * GRID_WIDTH) ? 6'(TOP_LEVEL) : 6'd0;
		end
	endfunction

	function automatic fire_rsp_t fire_step(input fire_req_t rq);
		fire_rsp_t   res;
		int unsigned idx;
		int unsigned src;
		int unsigned lvl;
		int unsigned dec;
		logic [23:0] rgb;
		res = '0;
		dec = rq.decay;
		case (rq.kind)
			REQ_PROPAGATE: begin
				idx = cur_row * GRID_WIDTH + cur_col;
				if (cur_row + 1 < GRID_HEIGHT) begin
					src = fire_levels[idx + GRID_WIDTH];
					lvl = (src > dec) ? src - dec : 0;
					if (idx >= dec) begin
						fire_levels[idx - dec] = 6'(lvl);
						res.wrote = 1'b1;
						res.written_index = 10'(idx - dec);
						res.written_level = 6'(lvl);
					end
				end
				cur_row++;
				if (cur_row >= GRID_HEIGHT) begin
					cur_row = 0;
					cur_col++;
					if (cur_col >= GRID_WIDTH) begin
						cur_col = 0;
						res.frame_done = 1'b1;
					end
				end
			end
			REQ_RESET: begin
				reset_grid();
			end
			REQ_READ: begin
				if (rq.cell_idx < CELL_COUNT) begin
					lvl = fire_levels[rq.cell_idx];
					if (lvl < PALETTE_SIZE) begin
						rgb = ember_rgb[lvl];
						res.color = rq.fmt ? rgb : {8'h00, rgb[23:19], rgb[15:10], rgb[7:3]};
					end
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic int idle_gap();
		int p;
		if (calm)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	task automatic issue(input fire_req_t rq, input logic typed, input fire_rsp_t typed_rs);
		fire_rsp_t want;
		int        gap;
		@(negedge clk);
		gap = idle_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.req_type     <= rq.kind;
		req_ch.decay        <= rq.decay;
		req_ch.cell_index   <= rq.cell_idx;
		req_ch.color_format <= rq.fmt;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		want = fire_step(rq);
		n_items++;
		n_writes += want.wrote;
		n_frames += want.frame_done;
		n_reads  += (rq.kind == REQ_READ);
		n_resets += (rq.kind == REQ_RESET);
		if (typed)
			want = typed_rs;
		pending_results.push_back(want);
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic compare_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		end
	endtask

	initial begin
		int stall;
		stall = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (!calm && $urandom_range(0, 99) < 25) begin
					stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 30);
				end
			end
		end
	end

	always @(posedge clk) begin
		fire_rsp_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				$display("%0t ns: unexpected result transfer, expected none, got %h", $time,
					{rsp_ch.wrote, rsp_ch.written_index, rsp_ch.written_level,
					rsp_ch.frame_done, rsp_ch.color});
			end else begin
				want = pending_results.pop_front();
				compare_field("wrote", want.wrote, rsp_ch.wrote);
				compare_field("written_index", want.written_index, rsp_ch.written_index);
				compare_field("written_level", want.written_level, rsp_ch.written_level);
				compare_field("frame_done", want.frame_done, rsp_ch.frame_done);
				compare_field("color", want.color, rsp_ch.color);
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		fire_req_t rq;
		int        p;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_NONE;
		req_ch.decay = '0;
		req_ch.cell_index = '0;
		req_ch.color_format = 1'b0;
		reset_grid();
		cur_col = 0;
		cur_row = 0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		for (int i = 0; i < $size(step_rows); i++) begin
			issue(step_rows[i].rq, step_rows[i].typed, step_rows[i].rs);
		end
		drain_results();

		for (int n = 0; n < RANDOM_ITEMS || n_frames == 0; n++) begin
			calm = ((n / 150) % 3) == 1;
			if ($urandom_range(0, 99) == 0)
				drain_results();
			p = $urandom_range(0, 99);
			if (p < 80)
				rq.kind = REQ_PROPAGATE;
			else if (p < 95)
				rq.kind = REQ_READ;
			else if (p < 98)
				rq.kind = REQ_RESET;
			else
				rq.kind = REQ_NONE;
			rq.decay = 2'($urandom_range(0, 3));
			rq.fmt = 1'($urandom_range(0, 1));
			rq.cell_idx = 10'($urandom_range(0, 1023));
			if (rq.kind == REQ_READ) begin
				p = $urandom_range(0, 9);
				if (p < 5) begin
					rq.cell_idx = 10'($urandom_range(0, GRID_HEIGHT - 1) * GRID_WIDTH
						+ (cur_col + GRID_WIDTH - $urandom_range(0, 1)) % GRID_WIDTH);
				end else if (p < 9) begin
					rq.cell_idx = 10'($urandom_range(0, CELL_COUNT - 1));
				end
			end
			issue(rq, 1'b0, '0);
		end
		calm = 1'b0;
		@(negedge clk);
		req_ch.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d requests: %0d cell writes, %0d finished frames,", n_items,
			n_writes, n_frames);
		$display("%0d color reads and %0d grid resets, with random stalls on both channels.",
			n_reads, n_resets);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
